FILE: rtl/sht128_pkg.sv
// ----------------------------------------------------------------------------
// Signed Hadamard transform package
// Shared constants, request and response payload types, datapath commands
// and controller states for the 128-point signed Walsh-Hadamard transform.
// ----------------------------------------------------------------------------
package sht128_pkg;

   localparam int LANES       = 4;
   localparam int LOG_LANES   = 2;
   localparam int SAMPLE_BITS = 16;
   localparam int COEFF_BITS  = 24;
   localparam int ROW_BITS    = LANES * COEFF_BITS;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_a;
      logic signed [SAMPLE_BITS-1:0] sample_b;
      logic signed [SAMPLE_BITS-1:0] sample_c;
      logic signed [SAMPLE_BITS-1:0] sample_d;
      logic        [LANES-1:0]       sign_flips;
   } req_payload_type;

   typedef struct packed {
      logic signed [COEFF_BITS-1:0] coeff_a;
      logic signed [COEFF_BITS-1:0] coeff_b;
      logic signed [COEFF_BITS-1:0] coeff_c;
      logic signed [COEFF_BITS-1:0] coeff_d;
      logic                         final_group;
   } rsp_payload_type;

   typedef struct packed {
      logic load_wr;
      logic bf_lo_wr;
      logic bf_hi_wr;
      logic rd_en;
   } dp_cmd_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_BF_RD,
      ST_BF_LO,
      ST_BF_HI,
      ST_OUT_RD,
      ST_OUT_SHOW
   } ctrl_state_type;

endpackage

FILE: rtl/signed_hadamard_transform_128_core.sv
// ----------------------------------------------------------------------------
// Signed Hadamard transform, 128 points
// Loads a block of sign-flipped samples four per request, computes the
// unnormalised Walsh-Hadamard transform in natural order and streams the
// coefficients four per response, marking the last one.
//
//   channel  direction  handshake             payload
//   req_     in         req_valid/req_stall   sht128_pkg::req_payload_type
//   rsp_     out        rsp_valid/rsp_stall   sht128_pkg::rsp_payload_type
//
// A block of R = POINTS/4 requests is loaded, transformed in place in the
// row memory by row-pair butterfly passes and then streamed out as R
// responses. The transform is paced by the single write port of the row
// memory: each row pair is read once, then written back as its lower row
// and then as its upper row.
// Reset is synchronous; the memory and read registers are not reset.
// Requests are stalled outside the load phase; a stalled response holds.
// ----------------------------------------------------------------------------
module signed_hadamard_transform_128_core #(
   parameter int POINTS = 128
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  sht128_pkg::req_payload_type  req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output sht128_pkg::rsp_payload_type  rsp_payload
);
   import sht128_pkg::*;

   localparam int ROW_LOG = $clog2(POINTS / LANES);

   dp_cmd_type            cmd;
   logic [ROW_LOG-1:0]    wr_addr;
   logic [ROW_LOG-1:0]    rd_addr_lo;
   logic [ROW_LOG-1:0]    rd_addr_hi;
   logic [ROW_BITS-1:0]   rd_row;
   logic                  rsp_final;

   sht128_ctrl #(
      .POINTS (POINTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_final  (rsp_final),
      .cmd        (cmd),
      .wr_addr    (wr_addr),
      .rd_addr_lo (rd_addr_lo),
      .rd_addr_hi (rd_addr_hi)
   );

   sht128_datapath #(
      .POINTS (POINTS)
   ) u_datapath (
      .clock       (clock),
      .cmd         (cmd),
      .wr_addr     (wr_addr),
      .rd_addr_lo  (rd_addr_lo),
      .rd_addr_hi  (rd_addr_hi),
      .req_payload (req_payload),
      .rd_row      (rd_row)
   );

   always_comb begin
      rsp_payload.coeff_a     = rd_row[0*COEFF_BITS +: COEFF_BITS];
      rsp_payload.coeff_b     = rd_row[1*COEFF_BITS +: COEFF_BITS];
      rsp_payload.coeff_c     = rd_row[2*COEFF_BITS +: COEFF_BITS];
      rsp_payload.coeff_d     = rd_row[3*COEFF_BITS +: COEFF_BITS];
      rsp_payload.final_group = rsp_final;
   end

endmodule

FILE: rtl/sht128_datapath.sv
// ----------------------------------------------------------------------------
// Signed Hadamard transform datapath
// Row memory of LANES coefficients per row, the load network that applies
// the sign flips and the in-row butterfly stages, and the row-pair
// butterfly unit used for the strides that span rows.
// ----------------------------------------------------------------------------
module sht128_datapath #(
   parameter int POINTS = 128
) (
   input  logic                                              clock,
   input  sht128_pkg::dp_cmd_type                            cmd,
   input  logic [$clog2(POINTS/sht128_pkg::LANES)-1:0]       wr_addr,
   input  logic [$clog2(POINTS/sht128_pkg::LANES)-1:0]       rd_addr_lo,
   input  logic [$clog2(POINTS/sht128_pkg::LANES)-1:0]       rd_addr_hi,
   input  sht128_pkg::req_payload_type                       req_payload,
   output logic [sht128_pkg::ROW_BITS-1:0]                   rd_row
);
   import sht128_pkg::*;

   localparam int ROWS = POINTS / LANES;

   logic [ROW_BITS-1:0]          work_store [ROWS];
   logic [ROW_BITS-1:0]          rd_lo_ff;
   logic [ROW_BITS-1:0]          rd_hi_ff;
   logic [ROW_BITS-1:0]          load_row;
   logic [ROW_BITS-1:0]          lo_row;
   logic [ROW_BITS-1:0]          hi_row;
   logic [ROW_BITS-1:0]          wr_row;
   logic signed [SAMPLE_BITS-1:0] samples [LANES];
   logic [COEFF_BITS-1:0]        net [LOG_LANES+1][LANES];

   always_comb begin
      samples[0] = req_payload.sample_a;
      samples[1] = req_payload.sample_b;
      samples[2] = req_payload.sample_c;
      samples[3] = req_payload.sample_d;
   end

   // Negation is done after sign extension, so the most negative sample
   // becomes its exact positive value.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (req_payload.sign_flips[l]) begin
            net[0][l] = -COEFF_BITS'(samples[l]);
         end else begin
            net[0][l] = COEFF_BITS'(samples[l]);
         end
      end
      for (int s = 0; s < LOG_LANES; s++) begin
         for (int j = 0; j < LANES; j++) begin
            if (((j >> s) & 1) == 0) begin
               net[s+1][j] = net[s][j] + net[s][j + (1 << s)];
            end else begin
               net[s+1][j] = net[s][j - (1 << s)] - net[s][j];
            end
         end
      end
      for (int l = 0; l < LANES; l++) begin
         load_row[l*COEFF_BITS +: COEFF_BITS] = net[LOG_LANES][l];
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         lo_row[l*COEFF_BITS +: COEFF_BITS] = rd_lo_ff[l*COEFF_BITS +: COEFF_BITS]
                                            + rd_hi_ff[l*COEFF_BITS +: COEFF_BITS];
         hi_row[l*COEFF_BITS +: COEFF_BITS] = rd_lo_ff[l*COEFF_BITS +: COEFF_BITS]
                                            - rd_hi_ff[l*COEFF_BITS +: COEFF_BITS];
      end
   end

   always_comb begin
      if (cmd.load_wr) begin
         wr_row = load_row;
      end else if (cmd.bf_lo_wr) begin
         wr_row = lo_row;
      end else begin
         wr_row = hi_row;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wr || cmd.bf_lo_wr || cmd.bf_hi_wr) begin
         work_store[wr_addr] <= wr_row;
      end
   end

   // The read registers hold across the lower-row and upper-row writes of a row pair.
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_lo_ff <= work_store[rd_addr_lo];
         rd_hi_ff <= work_store[rd_addr_hi];
      end
   end

   assign rd_row = rd_lo_ff;

endmodule

FILE: rtl/sht128_ctrl.sv
// ----------------------------------------------------------------------------
// Signed Hadamard transform controller
// Sequences loading, the row-pair butterfly passes and the output stream,
// and drives the datapath with commands and row addresses.
// ----------------------------------------------------------------------------
module sht128_ctrl #(
   parameter int POINTS = 128
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_valid,
   output logic                                          req_stall,
   output logic                                          rsp_valid,
   input  logic                                          rsp_stall,
   output logic                                          rsp_final,
   output sht128_pkg::dp_cmd_type                        cmd,
   output logic [$clog2(POINTS/sht128_pkg::LANES)-1:0]   wr_addr,
   output logic [$clog2(POINTS/sht128_pkg::LANES)-1:0]   rd_addr_lo,
   output logic [$clog2(POINTS/sht128_pkg::LANES)-1:0]   rd_addr_hi
);
   import sht128_pkg::*;

   localparam int ROWS       = POINTS / LANES;
   localparam int ROW_LOG    = $clog2(ROWS);
   localparam int PAIR_BITS  = ROW_LOG - 1;
   localparam int STAGE_BITS = $clog2(ROW_LOG);
   localparam logic [ROW_LOG-1:0]    LAST_ROW   = ROW_LOG'(ROWS - 1);
   localparam logic [PAIR_BITS-1:0]  LAST_PAIR  = PAIR_BITS'(ROWS / 2 - 1);
   localparam logic [STAGE_BITS-1:0] LAST_STAGE = STAGE_BITS'(ROW_LOG - 1);

   ctrl_state_type          state_ff;
   ctrl_state_type          state_in;
   logic [ROW_LOG-1:0]      row_ff;
   logic [ROW_LOG-1:0]      row_in;
   logic [PAIR_BITS-1:0]    pair_ff;
   logic [PAIR_BITS-1:0]    pair_in;
   logic [STAGE_BITS-1:0]   stage_ff;
   logic [STAGE_BITS-1:0]   stage_in;
   logic                    req_accept;
   logic                    rsp_accept;
   logic [ROW_LOG-1:0]      pair_ext;
   logic [ROW_LOG-1:0]      stride;
   logic [ROW_LOG-1:0]      low_mask;
   logic [ROW_LOG-1:0]      bf_lo;
   logic [ROW_LOG-1:0]      bf_hi;

   assign req_accept = (state_ff == ST_LOAD) && req_valid;
   assign rsp_accept = (state_ff == ST_OUT_SHOW) && !rsp_stall;

   // The pair index gets a zero bit inserted at the stride position to form
   // the lower row; the upper row sets that bit.
   always_comb begin
      pair_ext = {1'b0, pair_ff};
      stride   = ROW_LOG'(1) << stage_ff;
      low_mask = stride - ROW_LOG'(1);
      bf_lo    = (pair_ext & low_mask) | ((pair_ext & ~low_mask) << 1);
      bf_hi    = bf_lo | stride;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_accept && (row_ff == LAST_ROW)) begin
               state_in = ST_BF_RD;
            end
         end
         ST_BF_RD: begin
            state_in = ST_BF_LO;
         end
         ST_BF_LO: begin
            state_in = ST_BF_HI;
         end
         ST_BF_HI: begin
            if ((pair_ff == LAST_PAIR) && (stage_ff == LAST_STAGE)) begin
               state_in = ST_OUT_RD;
            end else begin
               state_in = ST_BF_RD;
            end
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_SHOW;
         end
         ST_OUT_SHOW: begin
            if (rsp_accept && (row_ff == LAST_ROW)) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      row_in   = row_ff;
      pair_in  = pair_ff;
      stage_in = stage_ff;
      if (req_accept || rsp_accept) begin
         row_in = row_ff + ROW_LOG'(1);
      end
      if (state_ff == ST_BF_HI) begin
         if (pair_ff == LAST_PAIR) begin
            pair_in = '0;
            if (stage_ff == LAST_STAGE) begin
               stage_in = '0;
            end else begin
               stage_in = stage_ff + STAGE_BITS'(1);
            end
         end else begin
            pair_in = pair_ff + PAIR_BITS'(1);
         end
      end
   end

   always_comb begin
      cmd        = '0;
      wr_addr    = row_ff;
      rd_addr_lo = bf_lo;
      rd_addr_hi = bf_hi;
      case (state_ff)
         ST_LOAD: begin
            cmd.load_wr = req_valid;
         end
         ST_BF_RD: begin
            cmd.rd_en = 1'b1;
         end
         ST_BF_LO: begin
            cmd.bf_lo_wr = 1'b1;
            wr_addr      = bf_lo;
         end
         ST_BF_HI: begin
            cmd.bf_hi_wr = 1'b1;
            wr_addr      = bf_hi;
         end
         ST_OUT_RD: begin
            cmd.rd_en  = 1'b1;
            rd_addr_lo = row_ff;
         end
         ST_OUT_SHOW: begin
            // Fetch the next row as the current one is taken.
            cmd.rd_en  = !rsp_stall && (row_ff != LAST_ROW);
            rd_addr_lo = row_ff + ROW_LOG'(1);
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_LOAD);
   assign rsp_valid = (state_ff == ST_OUT_SHOW);
   assign rsp_final = (row_ff == LAST_ROW);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         row_ff   <= '0;
         pair_ff  <= '0;
         stage_ff <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         pair_ff  <= pair_in;
         stage_ff <= stage_in;
      end
   end

`ifndef ASSERT_OFF
   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_wr, cmd.bf_lo_wr, cmd.bf_hi_wr, cmd.rd_en}))
      else $error("More than one datapath command in a cycle.");

   a_pair_rows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BF_RD) |-> (rd_addr_lo < rd_addr_hi) &&
                                 ($countones(rd_addr_lo ^ rd_addr_hi) == 1))
      else $error("Butterfly rows are not a valid pair.");

   a_stall_holds_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(row_ff))
      else $error("Output row moved while stalled.");

   a_block_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && (row_ff == LAST_ROW)) |=> (state_ff == ST_LOAD) && (row_ff == '0))
      else $error("Block did not return to loading after its last response.");

   a_load_end: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (row_ff == LAST_ROW)) |=> (state_ff == ST_BF_RD) &&
                                              (row_ff == '0) && (pair_ff == '0) &&
                                              (stage_ff == '0))
      else $error("Transform did not start cleanly after the last request.");
`endif

endmodule
